### design/calendar_date_stepper_core_macros.svh
// ----------------------------------------------------------------------------
// Calendar date stepper assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_STEPPER_CORE_MACROS_SVH
`define CALENDAR_DATE_STEPPER_CORE_MACROS_SVH

// Check an expression at every clock edge out of reset
`define CDSTEP_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("calendar date stepper: invariant violated");

// Check that a trigger is followed by a condition in the next cycle
`define CDSTEP_ASSERT_NEXT(name, trig, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("calendar date stepper: sequence violated");

`endif

### design/cdstep_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date stepper package
// Field widths, event codes, the date record and the month length function.
// ----------------------------------------------------------------------------
`default_nettype none

package cdstep_pkg;

    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OP_W    = 3;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;

    // Event codes; the remaining codes leave the date as is
    localparam op_t OP_LOAD       = 3'd0;
    localparam op_t OP_NEXT_DAY   = 3'd1;
    localparam op_t OP_PREV_DAY   = 3'd2;
    localparam op_t OP_NEXT_MONTH = 3'd3;
    localparam op_t OP_PREV_MONTH = 3'd4;

    typedef struct packed {
        year_t  year;
        month_t month;
        day_t   day;
    } date_t;

    localparam year_t  RESET_YEAR = 16'd2000;
    localparam month_t MONTH_JAN  = 4'd1;
    localparam month_t MONTH_FEB  = 4'd2;
    localparam month_t MONTH_DEC  = 4'd12;
    localparam day_t   DAY_FIRST  = 5'd1;
    localparam day_t   DAYS_28    = 5'd28;
    localparam day_t   DAYS_29    = 5'd29;
    localparam day_t   DAYS_30    = 5'd30;
    localparam day_t   DAYS_31    = 5'd31;

    // Divisibility by 25: multiply by the inverse of 25 mod 2^16 and compare
    localparam year_t INV_25      = 16'h5C29;
    localparam year_t DIV25_LIMIT = 16'd2621;

    // Leap-year flag from per-year divisibility bits
    typedef struct packed {
        logic by4;
        logic by16;
        logic by25;
    } year_div_t;

    function automatic day_t days_of(input month_t month, input logic leap);
        day_t len;
        case (month)
            MONTH_FEB:                   len = leap ? DAYS_29 : DAYS_28;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:          len = DAYS_31;
            default:                     len = DAYS_30;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### design/cdstep_leap.sv
// ----------------------------------------------------------------------------
// Calendar date stepper leap-year detector
// Gregorian leap rule on a 16-bit year, with no divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cdstep_leap (
    input  wire cdstep_pkg::year_t year,
    output logic                   leap
);
    import cdstep_pkg::*;

    year_t     prod;
    year_div_t div;

    // Test divisibility by 4, 16 and 25; 100 = 4*25, 400 = 16*25
    assign prod     = year_t'(year * INV_25);
    assign div.by4  = (year[1:0] == 2'b00);
    assign div.by16 = (year[3:0] == 4'b0000);
    assign div.by25 = (prod <= DIV25_LIMIT);

    assign leap = (div.by4 && !div.by25) || (div.by16 && div.by25);

endmodule

`default_nettype wire

### design/cdstep_update.sv
// ----------------------------------------------------------------------------
// Calendar date stepper update logic
// Next date from the stored date and one event.
// ----------------------------------------------------------------------------
`default_nettype none

module cdstep_update (
    input  wire cdstep_pkg::op_t   op,
    input  wire cdstep_pkg::date_t load,
    input  wire cdstep_pkg::date_t cur,
    input  wire                    leap,
    output cdstep_pkg::date_t      nxt
);
    import cdstep_pkg::*;

    date_t fwd;
    date_t back;
    day_t  cur_len;
    day_t  back_len;

    assign cur_len = days_of(cur.month, leap);

    // Step the month forward: December and above carry into January
    always_comb
    begin
        fwd.day = DAY_FIRST;
        if (cur.month >= MONTH_DEC)
        begin
            fwd.year  = cur.year + 16'd1;
            fwd.month = MONTH_JAN;
        end
        else
        begin
            fwd.year  = cur.year;
            fwd.month = cur.month + 4'd1;
        end
    end

    // Step the month back; a year borrow always lands in December,
    // whose length does not depend on the leap flag of the current year
    always_comb
    begin
        if (cur.month <= MONTH_JAN)
        begin
            back.year  = cur.year - 16'd1;
            back.month = MONTH_DEC;
        end
        else
        begin
            back.year  = cur.year;
            back.month = cur.month - 4'd1;
        end
        back_len = days_of(back.month, leap);
        back.day = back_len;
    end

    // Select the new date for the event
    always_comb
    begin
        nxt = cur;
        case (op)
            OP_LOAD:
            begin
                if (load.year != '0)
                    nxt.year = load.year;
                if (load.month != '0)
                    nxt.month = load.month;
                if (load.day != '0)
                    nxt.day = load.day;
            end
            OP_NEXT_DAY:
            begin
                if (cur.day >= cur_len)
                    nxt = fwd;
                else
                    nxt.day = cur.day + 5'd1;
            end
            OP_PREV_DAY:
            begin
                if (cur.day <= DAY_FIRST)
                    nxt = back;
                else
                    nxt.day = cur.day - 5'd1;
            end
            OP_NEXT_MONTH: nxt = fwd;
            OP_PREV_MONTH: nxt = back;
            default:       nxt = cur;
        endcase
    end

endmodule

`default_nettype wire

### design/calendar_date_stepper_core.sv
// ----------------------------------------------------------------------------
// Calendar date stepper core
// Holds a Gregorian date and steps it by one event per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on s_axis: tuser carries the event code (load, next
//   day, previous day, next month, previous month), tdata the load fields.
//   Each request yields one result on m_axis: the date after the event and
//   the length of that month.
//   The accepting edge puts the request in the input register; once the
//   result slot is free, the updated date is written into the state
//   register, which also serves as the result register and drives
//   m_axis_tvalid.
//   Throughput is one request per cycle while the receiver does not stall;
//   the loop through the date register and the update logic has no other register.
//   Reset sets the date to 2000-01-01 and empties both stages.
//   When the receiver stalls, the result holds; one more request waits in
//   the input register and s_axis_tready then drops until the result is
//   taken.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_stepper_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [2:0]  s_axis_tuser,  // [2:0] op
    input  wire  [31:0] s_axis_tdata,  // [15:0] load_year, [19:16] load_month,
                                       // [24:20] load_day, [31:25] zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata   // [15:0] cur_year, [19:16] cur_month,
                                       // [24:20] cur_day, [29:25] month_length,
                                       // [31:30] zero
);
    import cdstep_pkg::*;

    `include "calendar_date_stepper_core_macros.svh"

    logic  in_valid_reg;
    op_t   op_reg;
    date_t load_reg;
    logic  out_valid_reg;
    date_t date_reg;
    date_t date_next;
    logic  advance;
    logic  leap;
    day_t  month_length;
    logic  next_month_step;

    // Move a request into the update stage when the result slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg         <= s_axis_tuser;
            load_reg.year  <= s_axis_tdata[15:0];
            load_reg.month <= s_axis_tdata[19:16];
            load_reg.day   <= s_axis_tdata[24:20];
        end
    end

    cdstep_leap u_leap (
        .year (date_reg.year),
        .leap (leap)
    );

    cdstep_update u_update (
        .op   (op_reg),
        .load (load_reg),
        .cur  (date_reg),
        .leap (leap),
        .nxt  (date_next)
    );

    // Date register doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.year  <= RESET_YEAR;
            date_reg.month <= MONTH_JAN;
            date_reg.day   <= DAY_FIRST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                date_reg <= date_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Drive the result
    assign month_length  = days_of(date_reg.month, leap);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, month_length, date_reg.day, date_reg.month,
                            date_reg.year};

    // Checks
    assign next_month_step = advance && (op_reg == OP_NEXT_MONTH);

    `CDSTEP_ASSERT_ALWAYS(a_date_nonzero, (date_reg.day != '0) && (date_reg.month != '0))
    `CDSTEP_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_reg)
    `CDSTEP_ASSERT_NEXT(a_next_month_first_day, next_month_step, date_reg.day == DAY_FIRST)

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// Calendar date stepper testbench
// Drives load, day and month step requests into the date stepper over its
// stream ports and checks every result against a date predictor kept here.
// A directed run covers the year wrap, the leap rule and out-of-range
// loads. A random run of about 1500 requests follows, with bursts of idle
// cycles on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

    import cdstep_pkg::*;

    // Codes with no event behind them
    localparam op_t OP_SPARE_A = 3'd5;
    localparam op_t OP_SPARE_B = 3'd6;
    localparam op_t OP_SPARE_C = 3'd7;

    localparam int RANDOM_REQUESTS = 1500;
    localparam int CALM_FROM       = 1300;
    localparam int HOLD_OFF_AT     = 200;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int QUIET_LIMIT     = 1000;

    // Date predictor and the queue of dates still owed by the block
    class date_scoreboard;
        typedef struct {
            year_t  year;
            month_t month;
            day_t   day;
            day_t   len;
        } stepped_date_t;

        year_t         year_now;
        month_t        month_now;
        day_t          day_now;
        stepped_date_t expected_dates[$];
        int unsigned   errors;

        function new();
            year_now  = RESET_YEAR;
            month_now = MONTH_JAN;
            day_now   = DAY_FIRST;
            errors    = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function bit leap_year(year_t y);
            int unsigned yi;
            yi = y;
            return ((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0);
        endfunction

        function day_t month_days(year_t y, month_t m);
            case (m)
                MONTH_FEB: return leap_year(y) ? DAYS_29 : DAYS_28;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, MONTH_DEC: return DAYS_31;
                default:   return DAYS_30;
            endcase
        endfunction

        // Carry into the next month; anything from December up goes to January
        function void month_forward();
            if (month_now >= MONTH_DEC)
            begin
                year_now  = year_now + 1'b1;
                month_now = MONTH_JAN;
            end
            else
            begin
                month_now = month_now + 1'b1;
            end
        endfunction

        // Borrow from the previous month; January and zero go to December
        function void month_back();
            if (month_now <= MONTH_JAN)
            begin
                year_now  = year_now - 1'b1;
                month_now = MONTH_DEC;
            end
            else
            begin
                month_now = month_now - 1'b1;
            end
        endfunction

        // Apply one accepted request and queue the date it leads to
        function void note_request(op_t op, year_t ly, month_t lm, day_t ld);
            stepped_date_t exp_date;
            case (op)
                OP_LOAD:
                begin
                    if (ly != '0) year_now = ly;
                    if (lm != '0) month_now = lm;
                    if (ld != '0) day_now = ld;
                end
                OP_NEXT_DAY:
                begin
                    if (day_now >= month_days(year_now, month_now))
                    begin
                        month_forward();
                        day_now = DAY_FIRST;
                    end
                    else
                    begin
                        day_now = day_now + 1'b1;
                    end
                end
                OP_PREV_DAY:
                begin
                    if (day_now <= DAY_FIRST)
                    begin
                        month_back();
                        day_now = month_days(year_now, month_now);
                    end
                    else
                    begin
                        day_now = day_now - 1'b1;
                    end
                end
                OP_NEXT_MONTH:
                begin
                    month_forward();
                    day_now = DAY_FIRST;
                end
                OP_PREV_MONTH:
                begin
                    month_back();
                    day_now = month_days(year_now, month_now);
                end
                default: ;
            endcase
            exp_date.year  = year_now;
            exp_date.month = month_now;
            exp_date.day   = day_now;
            exp_date.len   = month_days(year_now, month_now);
            expected_dates.push_back(exp_date);
        endfunction

        // Compare one accepted result with the oldest queued date
        task check_result(input logic [31:0] data);
            stepped_date_t exp_date;
            if (expected_dates.size() == 0)
            begin
                report($sformatf("result 0x%08h with no request outstanding", data));
                return;
            end
            exp_date = expected_dates.pop_front();
            if (data[15:0] !== exp_date.year)
                report($sformatf("cur_year got %0d, expected %0d",
                                 data[15:0], exp_date.year));
            if (data[19:16] !== exp_date.month)
                report($sformatf("cur_month got %0d, expected %0d",
                                 data[19:16], exp_date.month));
            if (data[24:20] !== exp_date.day)
                report($sformatf("cur_day got %0d, expected %0d",
                                 data[24:20], exp_date.day));
            if (data[29:25] !== exp_date.len)
                report($sformatf("month_length got %0d, expected %0d",
                                 data[29:25], exp_date.len));
            if (data[31:30] !== 2'b00)
                report($sformatf("padding bits got %b, expected 00", data[31:30]));
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser  = '0;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    date_scoreboard sb = new();

    bit idle_on      = 1'b1;
    bit hold_off_req = 1'b0;

    calendar_date_stepper_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tuser  (s_tuser),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one request, optionally after a short gap, and wait for acceptance
    task automatic send_request(input op_t op, input year_t y, input month_t m,
                                input day_t d);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, d, m, y};
        do @(posedge clk); while (!s_tready);
        sb.note_request(op, y, m, d);
    endtask

    function automatic year_t pick_year();
        case ($urandom_range(0, 7))
            0:       return year_t'($urandom_range(0, 65535));
            1:       return '0;
            2:       return 16'hFFFF;
            3:       return year_t'($urandom_range(0, 163) * 400);
            4:       return year_t'($urandom_range(0, 655) * 100);
            5:       return year_t'($urandom_range(0, 16383) * 4);
            default: return year_t'($urandom_range(1890, 2110));
        endcase
    endfunction

    function automatic month_t pick_month();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 12)
            return month_t'(r + 1);
        return month_t'($urandom_range(0, 15));
    endfunction

    // Favor days near the end of a month so carries happen often
    function automatic day_t pick_day();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r < 6)
            return day_t'($urandom_range(26, 31));
        return day_t'($urandom_range(0, 31));
    endfunction

    function automatic op_t pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return OP_LOAD;
        if (r < 47) return OP_NEXT_DAY;
        if (r < 72) return OP_PREV_DAY;
        if (r < 83) return OP_NEXT_MONTH;
        if (r < 94) return OP_PREV_MONTH;
        return op_t'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    endfunction

    // Year wrap, leap rule, out-of-range loads and the spare codes
    task automatic run_directed();
        send_request(OP_NEXT_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_LOAD,       16'hFFFF,  4'd12, 5'd31);
        send_request(OP_NEXT_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_PREV_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_NEXT_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_LOAD,       16'd0,     4'd2,  5'd28);
        send_request(OP_NEXT_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_NEXT_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_PREV_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_LOAD,       16'd1900,  4'd2,  5'd28);
        send_request(OP_NEXT_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_LOAD,       16'd2100,  4'd2,  5'd29);
        send_request(OP_NEXT_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_LOAD,       16'd2000,  4'd15, 5'd31);
        send_request(OP_NEXT_DAY,   16'd0,     4'd0,  5'd0);
        send_request(OP_LOAD,       16'd0,     4'd13, 5'd0);
        send_request(OP_PREV_MONTH, 16'd0,     4'd0,  5'd0);
        send_request(OP_LOAD,       16'd0,     4'd14, 5'd5);
        send_request(OP_NEXT_MONTH, 16'd0,     4'd0,  5'd0);
        send_request(OP_PREV_MONTH, 16'd0,     4'd0,  5'd0);
        send_request(OP_LOAD,       16'd0,     4'd0,  5'd0);
        send_request(OP_SPARE_A,    16'hFFFF,  4'hF,  5'h1F);
        send_request(OP_SPARE_B,    16'h5555,  4'h5,  5'h15);
        send_request(OP_SPARE_C,    16'hAAAA,  4'hA,  5'h0A);
        send_request(OP_LOAD,       16'd2024,  4'd3,  5'd1);
        send_request(OP_PREV_DAY,   16'd0,     4'd0,  5'd0);
    endtask

    // Random events, with idle stretches switched on and off by phase
    task automatic run_random();
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            idle_on = (i < CALM_FROM) && ((i / 100) % 3 != 2);
            if (i == HOLD_OFF_AT)
                hold_off_req = 1'b1;
            send_request(pick_op(), pick_year(), pick_month(), pick_day());
        end
    endtask

    // Result side: check accepted results and stall in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (stall_left == 0 && hold_off_req)
            begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no request or result moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        while (sb.expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
